// ===== sv/pba_pkg.sv =====
// Shared types, constants and helpers of the page bitmap allocator.
`default_nettype none

package pba_pkg;

  localparam int PAGES_DEF  = 32768;  // built size of the managed heap, in pages
  localparam int WORD_BITS  = 64;     // pages held in one bitmap memory word
  localparam int OFF_W      = 6;      // page offset within a bitmap word
  localparam int PAGE_SHIFT = 12;     // 4 KiB pages
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] REG_HEAP_BASE    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_PAGES_IN_USE = 1'b1;

  localparam logic [15:0] PAGES_IN_USE_RST = 16'd32768;

  typedef enum logic [1:0] {
    FN_ALLOC_ONE = 2'd0,
    FN_ALLOC_RUN = 2'd1,
    FN_FREE_ONE  = 2'd2,
    FN_FREE_RUN  = 2'd3
  } func_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN_RD,
    ST_SCAN,
    ST_CHUNK,
    ST_FREE_IDX,
    ST_FREE_END,
    ST_PASS_RD,
    ST_PASS_WR,
    ST_DONE
  } state_e;

  // one bitmap word handed to the search logic, with the in-range window
  typedef struct packed {
    logic [WORD_BITS-1:0] data;
    logic [OFF_W-1:0]     lo_off;     // first page of the window
    logic [OFF_W:0]       hi_off;     // one past the last page, up to 64
    logic [15:0]          run;        // free run carried in from earlier pages
    logic [15:0]          count;      // wanted run length
    logic [2:0]           chunk;      // byte of the word for bitwise stepping
    logic                 chunk_mode;
  } scan_req_t;

  typedef struct packed {
    logic             one_found;
    logic [OFF_W-1:0] one_off;
    logic             none_free;
    logic             all_free;
    logic             run_found;
    logic [OFF_W-1:0] run_off;      // page that completes the run
    logic [15:0]      run_next;
  } scan_res_t;

  // bits lo .. hi-1 set
  function automatic logic [WORD_BITS-1:0] range_mask(input logic [OFF_W-1:0] lo,
                                                       input logic [OFF_W:0]   hi);
    logic [WORD_BITS-1:0] m;
    for (int k = 0; k < WORD_BITS; k++) begin
      m[k] = (k >= int'(lo)) && (k < int'(hi));
    end
    return m;
  endfunction

endpackage

`default_nettype wire

// ===== sv/pba_bitmap_ram.sv =====
// Used-page bitmap memory: one write port, one registered read port.
`default_nettype none

module pba_bitmap_ram import pba_pkg::*; #(
  parameter int WORDS = PAGES_DEF / WORD_BITS,
  parameter int AW    = $clog2(PAGES_DEF / WORD_BITS)
) (
  input  wire logic                 clk_i,
  input  wire logic                 we_i,
  input  wire logic [AW-1:0]        waddr_i,
  input  wire logic [WORD_BITS-1:0] wdata_i,
  input  wire logic                 re_i,
  input  wire logic [AW-1:0]        raddr_i,
  output logic      [WORD_BITS-1:0] rdata_o
);

  logic [WORD_BITS-1:0] mem [WORDS];
  logic [WORD_BITS-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== sv/pba_word_scan.sv =====
// Free-page and free-run search over one bitmap word.
`default_nettype none

module pba_word_scan import pba_pkg::*; (
  input  wire scan_req_t req_i,
  output scan_res_t      res_o
);

  logic [WORD_BITS-1:0] win;
  logic [WORD_BITS-1:0] free_m;
  logic [WORD_BITS-1:0] used_m;
  logic [OFF_W-1:0]     first_free;
  logic [OFF_W:0]       span;
  logic [15:0]          need;
  logic                 word_found;
  logic [OFF_W:0]       word_last;
  logic [15:0]          c_run;
  logic                 c_found;
  logic [OFF_W-1:0]     c_off;
  logic [OFF_W-1:0]     k;

  assign win    = range_mask(req_i.lo_off, req_i.hi_off);
  assign free_m = ~req_i.data & win;
  assign used_m = req_i.data & win;

  always_comb begin
    first_free = '0;
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (free_m[b]) first_free = OFF_W'(b);
    end
  end

  // whole window free: the run either completes inside it or grows by its span
  assign span       = req_i.hi_off - {1'b0, req_i.lo_off};
  assign need       = req_i.count - req_i.run;
  assign word_found = {9'b0, span} >= need;
  assign word_last  = {1'b0, req_i.lo_off} + need[OFF_W:0] - 7'd1;

  // mixed window: step through one byte of pages
  always_comb begin
    c_run   = req_i.run;
    c_found = 1'b0;
    c_off   = '0;
    k       = '0;
    for (int j = 0; j < 8; j++) begin
      k = {req_i.chunk, j[2:0]};
      if (!c_found && win[k]) begin
        if (req_i.data[k]) begin
          c_run = '0;
        end else begin
          c_run = c_run + 16'd1;
          if (c_run == req_i.count) begin
            c_found = 1'b1;
            c_off   = k;
          end
        end
      end
    end
  end

  always_comb begin
    res_o.one_found = |free_m;
    res_o.one_off   = first_free;
    res_o.none_free = ~|free_m;
    res_o.all_free  = ~|used_m;
    if (req_i.chunk_mode) begin
      res_o.run_found = c_found;
      res_o.run_off   = c_off;
      res_o.run_next  = c_run;
    end else begin
      res_o.run_found = word_found;
      res_o.run_off   = word_last[OFF_W-1:0];
      res_o.run_next  = req_i.run + 16'(span);
    end
  end

endmodule

`default_nettype wire

// ===== sv/page_bitmap_allocator_unit.sv =====
// Next-fit page frame allocator over a one-bit-per-page used map.
//
// The used map sits in a memory of 64-page words with a registered read; every
// request reads, edits and writes back words one at a time, one request in
// flight. Allocate-one reads and checks each word from the search hint on,
// then reads and writes back the word to mark the page. Allocate-run passes
// over each word that is wholly free or wholly used inside the window at once
// and steps through a mixed word byte by byte, then reads and writes back each
// word covered by the run to mark it. Frees find the page index and the end of
// the range, then read and write back each word touched. Rejected requests make
// no memory access. After reset the map is cleared word by word, during which
// no request is taken; configuration writes are taken at any time. The result
// register lets a new request in while the previous result waits.
`default_nettype none

module page_bitmap_allocator_unit import pba_pkg::*; #(
  parameter int PAGES = PAGES_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // configuration write port
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i,
  // request stream
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [79:0]           s_axis_tdata,   // address[63:0], count[79:64]
  input  wire logic [1:0]            s_axis_tuser,   // func[1:0]
  // result stream
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output logic [63:0]                m_axis_tdata,   // address_out[63:0]
  output logic [0:0]                 m_axis_tuser    // ok[0]
);

  localparam int WORDS = (PAGES + WORD_BITS - 1) / WORD_BITS;
  localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int IW    = $clog2(WORDS * WORD_BITS + 1);
  localparam int WIW   = IW - OFF_W;

  state_e state_q, state_d;

  logic [63:0]    heap_base_q;
  logic [15:0]    piu_q;
  logic [IW-1:0]  hint_q, hint_d;
  logic [WIW-1:0] clr_q, clr_d;
  logic           ok_q, ok_d;
  logic           set_q, set_d;
  logic           out_valid_q;
  logic           out_load;

  func_e          func_q, func_d;
  logic [63:0]    addr_q, addr_d;
  logic [15:0]    count_q, count_d;
  logic [IW-1:0]  pos_q, pos_d;
  logic [15:0]    run_q, run_d;
  logic [2:0]     chunk_q, chunk_d;
  logic [IW-1:0]  lo_q, lo_d;
  logic [IW-1:0]  hi_q, hi_d;
  logic [IW-1:0]  first_q, first_d;
  logic [63:0]    out_addr_q;
  logic           out_ok_q;

  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [WORD_BITS-1:0] ram_wdata;
  logic                 ram_re;
  logic [AW-1:0]        ram_raddr;
  logic [WORD_BITS-1:0] ram_rdata;

  scan_req_t scan_req;
  scan_res_t scan_res;

  logic [IW-1:0]        lim;
  logic [IW-1:0]        pos_next;
  logic [IW-1:0]        one_idx;
  logic [IW-1:0]        run_last;
  logic [IW-1:0]        run_first;
  logic [63:0]          diff;
  logic [IW-1:0]        free_idx;
  logic [31:0]          free_n;
  logic [31:0]          free_rem;
  logic [IW-1:0]        free_end;
  logic [OFF_W:0]       pass_hi_off;
  logic [WORD_BITS-1:0] pass_mask;
  logic                 is_alloc;

  assign lim = (32'(piu_q) > 32'(PAGES)) ? IW'(PAGES) : IW'(piu_q);

  pba_bitmap_ram #(
    .WORDS (WORDS),
    .AW    (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    scan_req.data       = ram_rdata;
    scan_req.lo_off     = pos_q[OFF_W-1:0];
    scan_req.hi_off     = (lim[IW-1:OFF_W] == pos_q[IW-1:OFF_W]) ?
                          {1'b0, lim[OFF_W-1:0]} : 7'(WORD_BITS);
    scan_req.run        = run_q;
    scan_req.count      = count_q;
    scan_req.chunk      = chunk_q;
    scan_req.chunk_mode = (state_q == ST_CHUNK);
  end

  pba_word_scan u_scan (
    .req_i (scan_req),
    .res_o (scan_res)
  );

  assign pos_next  = {pos_q[IW-1:OFF_W] + 1'b1, {OFF_W{1'b0}}};
  assign one_idx   = {pos_q[IW-1:OFF_W], scan_res.one_off};
  assign run_last  = {pos_q[IW-1:OFF_W], scan_res.run_off};
  assign run_first = IW'(32'(run_last) + 32'd1 - 32'(count_q));

  // page index of a freed address, wrapping below the heap base
  assign diff     = addr_q - heap_base_q;
  assign free_idx = diff[IW+PAGE_SHIFT-1:PAGE_SHIFT];
  assign free_n   = (func_q == FN_FREE_ONE) ? 32'd1 : 32'(count_q);
  assign free_rem = 32'(lim) - 32'(lo_q);
  assign free_end = (free_n > free_rem) ? lim : IW'(32'(lo_q) + free_n);

  assign pass_hi_off = (hi_q[IW-1:OFF_W] == lo_q[IW-1:OFF_W]) ?
                       {1'b0, hi_q[OFF_W-1:0]} : 7'(WORD_BITS);
  assign pass_mask   = range_mask(lo_q[OFF_W-1:0], pass_hi_off);

  assign is_alloc = (func_q == FN_ALLOC_ONE) || (func_q == FN_ALLOC_RUN);

  always_comb begin
    state_d   = state_q;
    hint_d    = hint_q;
    clr_d     = clr_q;
    ok_d      = ok_q;
    set_d     = set_q;
    func_d    = func_q;
    addr_d    = addr_q;
    count_d   = count_q;
    pos_d     = pos_q;
    run_d     = run_q;
    chunk_d   = chunk_q;
    lo_d      = lo_q;
    hi_d      = hi_q;
    first_d   = first_q;
    ram_we    = 1'b0;
    ram_waddr = lo_q[AW+OFF_W-1:OFF_W];
    ram_wdata = set_q ? (ram_rdata | pass_mask) : (ram_rdata & ~pass_mask);
    ram_re    = 1'b0;
    ram_raddr = pos_q[AW+OFF_W-1:OFF_W];
    out_load  = 1'b0;

    unique case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q[AW-1:0];
        ram_wdata = '0;
        clr_d     = clr_q + 1'b1;
        if (clr_q == WIW'(WORDS - 1)) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          func_d  = func_e'(s_axis_tuser);
          addr_d  = s_axis_tdata[63:0];
          count_d = s_axis_tdata[79:64];
          pos_d   = hint_q;
          run_d   = '0;
          ok_d    = 1'b0;
          first_d = '0;
          if (func_e'(s_axis_tuser) == FN_FREE_ONE ||
              func_e'(s_axis_tuser) == FN_FREE_RUN) begin
            state_d = ST_FREE_IDX;
          end else if (func_e'(s_axis_tuser) == FN_ALLOC_RUN &&
                       s_axis_tdata[79:64] == 16'd0) begin
            state_d = ST_DONE;
          end else begin
            state_d = ST_SCAN_RD;
          end
        end
      end
      ST_SCAN_RD: begin
        if (pos_q >= lim) begin
          // search ran off the end; a failed single allocation parks the hint
          if (func_q == FN_ALLOC_ONE && hint_q < lim) hint_d = lim;
          state_d = ST_DONE;
        end else begin
          ram_re  = 1'b1;
          chunk_d = '0;
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (func_q == FN_ALLOC_ONE) begin
          if (scan_res.one_found) begin
            lo_d    = one_idx;
            first_d = one_idx;
            hint_d  = one_idx;
            hi_d    = one_idx + 1'b1;
            ok_d    = 1'b1;
            set_d   = 1'b1;
            state_d = ST_PASS_RD;
          end else begin
            pos_d   = pos_next;
            state_d = ST_SCAN_RD;
          end
        end else if (scan_res.none_free) begin
          run_d   = '0;
          pos_d   = pos_next;
          state_d = ST_SCAN_RD;
        end else if (scan_res.all_free) begin
          if (scan_res.run_found) begin
            lo_d    = run_first;
            first_d = run_first;
            hi_d    = run_last + 1'b1;
            ok_d    = 1'b1;
            set_d   = 1'b1;
            state_d = ST_PASS_RD;
          end else begin
            run_d   = scan_res.run_next;
            pos_d   = pos_next;
            state_d = ST_SCAN_RD;
          end
        end else begin
          state_d = ST_CHUNK;
        end
      end
      ST_CHUNK: begin
        if (scan_res.run_found) begin
          lo_d    = run_first;
          first_d = run_first;
          hi_d    = run_last + 1'b1;
          ok_d    = 1'b1;
          set_d   = 1'b1;
          state_d = ST_PASS_RD;
        end else begin
          run_d = scan_res.run_next;
          if (chunk_q == 3'd7) begin
            pos_d   = pos_next;
            state_d = ST_SCAN_RD;
          end else begin
            chunk_d = chunk_q + 3'd1;
          end
        end
      end
      ST_FREE_IDX: begin
        if (diff[63:PAGE_SHIFT] < (64 - PAGE_SHIFT)'(lim)) begin
          lo_d  = free_idx;
          ok_d  = 1'b1;
          set_d = 1'b0;
          if (free_idx < hint_q) hint_d = free_idx;
          state_d = ST_FREE_END;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_FREE_END: begin
        hi_d    = free_end;
        state_d = ST_PASS_RD;
      end
      ST_PASS_RD: begin
        if (lo_q >= hi_q) begin
          state_d = ST_DONE;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = lo_q[AW+OFF_W-1:OFF_W];
          state_d   = ST_PASS_WR;
        end
      end
      ST_PASS_WR: begin
        ram_we  = 1'b1;
        lo_d    = {lo_q[IW-1:OFF_W] + 1'b1, {OFF_W{1'b0}}};
        state_d = ST_PASS_RD;
      end
      ST_DONE: begin
        if (!out_valid_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      hint_q      <= '0;
      clr_q       <= '0;
      ok_q        <= 1'b0;
      set_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      hint_q  <= hint_d;
      clr_q   <= clr_d;
      ok_q    <= ok_d;
      set_q   <= set_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heap_base_q <= '0;
      piu_q       <= PAGES_IN_USE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_HEAP_BASE:    heap_base_q <= cfg_wdata_i;
        REG_PAGES_IN_USE: piu_q       <= cfg_wdata_i[15:0];
        default:          heap_base_q <= heap_base_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    func_q  <= func_d;
    addr_q  <= addr_d;
    count_q <= count_d;
    pos_q   <= pos_d;
    run_q   <= run_d;
    chunk_q <= chunk_d;
    lo_q    <= lo_d;
    hi_q    <= hi_d;
    first_q <= first_d;
    if (out_load) begin
      out_ok_q   <= ok_q;
      out_addr_q <= (ok_q && is_alloc) ?
                    heap_base_q + (64'(first_q) << PAGE_SHIFT) : 64'd0;
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_addr_q;
  assign m_axis_tuser  = out_ok_q;

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
// Self-checking testbench of the page bitmap allocator: directed table, then randomized phases.
`default_nettype none

module tb_top;
  import pba_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SHADOW_PAGES = PAGES_DEF;
  localparam int          IDLE_TAIL = 32;
  localparam int          LONG_HOLD = 400;
  localparam int          NDIR      = 21;

  typedef struct packed {
    logic [63:0] addr;
    logic        ok;
  } alloc_rsp_t;

  typedef struct packed {
    func_e       fn;
    logic [63:0] addr;
    logic [15:0] cnt;
    logic        typed;
    logic [63:0] want_addr;
    logic        want_ok;
  } dir_row_t;

  logic                  clk_i = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  req_valid = 1'b0;
  logic [79:0]           req_data = '0;
  logic [1:0]            req_func = '0;
  logic                  rsp_ready = 1'b0;
  wire logic             s_axis_tready;
  wire logic             m_axis_tvalid;
  wire logic [63:0]      m_axis_tdata;
  wire logic [0:0]       m_axis_tuser;

  page_bitmap_allocator_unit i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_wdata_i   (cfg_wdata),
    .s_axis_tvalid (req_valid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (req_data),
    .s_axis_tuser  (req_func),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (rsp_ready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // shadow allocator state
  bit          page_used [SHADOW_PAGES];
  int unsigned hint_q;
  logic [63:0] heap_base_q = 64'h0;
  logic [15:0] pages_cfg_q = PAGES_IN_USE_RST;

  alloc_rsp_t  rsp_expected_q [$];
  int          errors = 0;
  int          rsp_seen = 0;
  int          tx_gap = 0;
  bit          tx_calm = 1'b0;
  bit          rx_calm = 1'b0;
  bit          held_once = 1'b0;
  dir_row_t    dir_tab [NDIR];

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #1_000_000_000;
    $display("Test completed with failures");
    $finish;
  end

  function automatic int unsigned managed_pages();
    return (int'(pages_cfg_q) > SHADOW_PAGES) ? SHADOW_PAGES : int'(pages_cfg_q);
  endfunction

  function automatic void predict_page_request(input func_e f, input logic [63:0] a,
                                               input logic [15:0] c, output alloc_rsp_t r);
    int unsigned lim;
    int unsigned i;
    int unsigned run;
    int unsigned idx;
    int unsigned n;
    int unsigned stop;
    bit          found;
    logic [63:0] idx64;
    lim = managed_pages();
    r = '0;
    case (f)
      FN_ALLOC_ONE: begin
        i = hint_q;
        while (i < lim && page_used[i]) i++;
        if (i < lim) begin
          page_used[i] = 1'b1;
          hint_q = i;
          r.addr = heap_base_q + (64'(i) << PAGE_SHIFT);
          r.ok = 1'b1;
        end else if (hint_q < lim) begin
          hint_q = lim;
        end
      end
      FN_ALLOC_RUN: begin
        if (c != 16'd0) begin
          run = 0;
          found = 1'b0;
          i = hint_q;
          while (i < lim && !found) begin
            if (page_used[i]) begin
              run = 0;
            end else begin
              run++;
              if (run == int'(c)) found = 1'b1;
            end
            if (!found) i++;
          end
          if (found) begin
            for (int unsigned j = i + 1 - int'(c); j <= i; j++) page_used[j] = 1'b1;
            r.addr = heap_base_q + (64'(i + 1 - int'(c)) << PAGE_SHIFT);
            r.ok = 1'b1;
          end
        end
      end
      default: begin
        idx64 = (a - heap_base_q) >> PAGE_SHIFT;
        if (idx64 < 64'(lim)) begin
          idx = int'(idx64);
          n = (f == FN_FREE_ONE) ? 1 : int'(c);
          if (idx < hint_q) hint_q = idx;
          stop = (n > lim - idx) ? lim : idx + n;
          for (int unsigned j = idx; j < stop; j++) page_used[j] = 1'b0;
          r.ok = 1'b1;
        end
      end
    endcase
  endfunction

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    errors++;
    $display("MISMATCH %s: got %h want %h", what, got, want);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
    @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    if (idx == REG_HEAP_BASE) heap_base_q = val;
    else pages_cfg_q = val[15:0];
  endtask

  // offer one request, predict at acceptance; valid stays up only if the next gap is zero
  task automatic issue_request(input func_e f, input logic [63:0] a, input logic [15:0] c,
                               input bit typed, input alloc_rsp_t want);
    alloc_rsp_t pred;
    if (tx_gap > 0) repeat (tx_gap) @(posedge clk_i);
    req_valid <= 1'b1;
    req_func <= f;
    req_data <= {c, a};
    // ready is registered, so its value between edges decides the next edge
    do @(negedge clk_i); while (!s_axis_tready);
    @(posedge clk_i);
    predict_page_request(f, a, c, pred);
    rsp_expected_q.push_back(typed ? want : pred);
    tx_gap = tx_calm ? 0 : $urandom_range(0, 17);
    if (tx_gap > 0) req_valid <= 1'b0;
  endtask

  task automatic wait_idle();
    req_valid <= 1'b0;
    while (rsp_expected_q.size() != 0) @(posedge clk_i);
    repeat (IDLE_TAIL) @(posedge clk_i);
  endtask

  task automatic run_phase(input logic [63:0] base, input logic [15:0] pages, input int n);
    int unsigned lim;
    int unsigned idx;
    int          r;
    func_e       f;
    logic [63:0] a;
    logic [15:0] c;
    write_reg(REG_HEAP_BASE, base);
    write_reg(REG_PAGES_IN_USE, {48'h0, pages});
    lim = managed_pages();
    for (int k = 0; k < n; k++) begin
      tx_calm = (k >= n / 2) && (k < n / 2 + 40);
      rx_calm = tx_calm;
      r = $urandom_range(0, 99);
      a = {$urandom, $urandom};
      c = 16'($urandom);
      idx = $urandom_range(0, lim + lim / 8 + 1);
      if (r < 5) begin
        f = func_e'($urandom_range(0, 3));
      end else if (r < 35) begin
        f = FN_ALLOC_ONE;
      end else if (r < 55) begin
        f = FN_ALLOC_RUN;
        r = $urandom_range(0, 19);
        if (r == 0) c = 16'd0;
        else if (r < 3) c = 16'($urandom_range(1, (lim > 0) ? lim : 1));
        else c = 16'($urandom_range(1, 8));
      end else begin
        f = ($urandom_range(0, 2) != 0) ? FN_FREE_ONE : FN_FREE_RUN;
        a = heap_base_q + (64'(idx) << PAGE_SHIFT) + 64'($urandom_range(0, 4095));
        c = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, SHADOW_PAGES))
                                          : 16'($urandom_range(0, 16));
      end
      issue_request(f, a, c, 1'b0, '0);
    end
    tx_calm = 1'b0;
    rx_calm = 1'b0;
    wait_idle();
  endtask

  // result side: random stall per item, one long hold-off
  initial begin
    int         stall;
    alloc_rsp_t w;
    wait (rst_n);
    forever begin
      stall = rx_calm ? 0 : $urandom_range(0, 17);
      if (rsp_seen == 150 && !held_once) begin
        stall = LONG_HOLD;
        held_once = 1'b1;
      end
      if (stall > 0) begin
        rsp_ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      rsp_ready <= 1'b1;
      // valid and data are registered: check between edges, the item moves at the next edge
      do @(negedge clk_i); while (!m_axis_tvalid);
      rsp_seen++;
      if (rsp_expected_q.size() == 0) begin
        report("result with nothing pending", m_axis_tdata, 64'h0);
      end else begin
        w = rsp_expected_q.pop_front();
        if (m_axis_tdata !== w.addr) report("address_out", m_axis_tdata, w.addr);
        if (m_axis_tuser[0] !== w.ok) report("ok", 64'(m_axis_tuser[0]), 64'(w.ok));
      end
      @(posedge clk_i);
    end
  end

  initial begin
    alloc_rsp_t want;
    // defaults after reset: heap_base 0, all pages managed, map empty, hint at 0
    dir_tab[0]  = '{FN_ALLOC_ONE, 64'h0,          16'd0,     1'b1, 64'h0,       1'b1};
    dir_tab[1]  = '{FN_ALLOC_ONE, 64'h0,          16'd0,     1'b1, 64'h1000,    1'b1};
    dir_tab[2]  = '{FN_ALLOC_RUN, 64'h0,          16'd0,     1'b1, 64'h0,       1'b0};
    dir_tab[3]  = '{FN_ALLOC_RUN, 64'h0,          16'd4,     1'b1, 64'h2000,    1'b1};
    dir_tab[4]  = '{FN_FREE_ONE,  64'h0,          16'd0,     1'b1, 64'h0,       1'b1};
    dir_tab[5]  = '{FN_FREE_ONE,  '1,             16'hFFFF,  1'b1, 64'h0,       1'b0};
    dir_tab[6]  = '{FN_FREE_RUN,  64'h1000,       16'd0,     1'b1, 64'h0,       1'b1};
    dir_tab[7]  = '{FN_ALLOC_ONE, 64'h0,          16'd0,     1'b1, 64'h0,       1'b1};
    // run longer than the map: cleared only up to the limit
    dir_tab[8]  = '{FN_FREE_RUN,  64'h0,          16'hFFFF,  1'b1, 64'h0,       1'b1};
    dir_tab[9]  = '{FN_ALLOC_RUN, 64'h0,          16'd32768, 1'b1, 64'h0,       1'b1};
    dir_tab[10] = '{FN_ALLOC_ONE, 64'h0,          16'd0,     1'b1, 64'h0,       1'b0};
    dir_tab[11] = '{FN_ALLOC_RUN, 64'h0,          16'd1,     1'b1, 64'h0,       1'b0};
    dir_tab[12] = '{FN_FREE_ONE,  64'h7FF_FFFF,   16'd0,     1'b1, 64'h0,       1'b1};
    dir_tab[13] = '{FN_ALLOC_ONE, 64'h0,          16'd0,     1'b1, 64'h7FFF000, 1'b1};
    dir_tab[14] = '{FN_FREE_ONE,  64'h800_0000,   16'd0,     1'b1, 64'h0,       1'b0};
    dir_tab[15] = '{FN_FREE_RUN,  64'h1000,       16'd8,     1'b1, 64'h0,       1'b1};
    dir_tab[16] = '{FN_ALLOC_RUN, 64'h0,          16'd9,     1'b1, 64'h0,       1'b0};
    dir_tab[17] = '{FN_ALLOC_RUN, 64'h0,          16'd8,     1'b1, 64'h1000,    1'b1};
    dir_tab[18] = '{FN_FREE_RUN,  64'h8000,       16'd32768, 1'b1, 64'h0,       1'b1};
    dir_tab[19] = '{FN_ALLOC_RUN, 64'h0,          16'h7FFF,  1'b1, 64'h0,       1'b0};
    dir_tab[20] = '{FN_ALLOC_ONE, 64'h0,          16'd0,     1'b0, 64'h0,       1'b0};

    hint_q = 0;
    repeat (5) @(posedge clk_i);
    rst_n <= 1'b1;

    for (int k = 0; k < NDIR; k++) begin
      want.addr = dir_tab[k].want_addr;
      want.ok = dir_tab[k].want_ok;
      issue_request(dir_tab[k].fn, dir_tab[k].addr, dir_tab[k].cnt, dir_tab[k].typed, want);
    end
    wait_idle();

    run_phase(64'h0, 16'd64, 200);
    run_phase({$urandom, $urandom}, 16'd200, 300);
    run_phase('1, 16'd1, 100);
    // addresses wrap past the top of the space
    run_phase(64'hFFFF_FFFF_FFF0_0000, 16'd1000, 300);
    run_phase({$urandom, $urandom}, 16'd32768, 200);
    // nothing managed: every request fails or is rejected
    run_phase({$urandom, $urandom}, 16'd0, 50);
    run_phase({$urandom, $urandom}, 16'hFFFF, 150);
    // lowered limit leaves the hint beyond it
    run_phase({$urandom, $urandom}, 16'd100, 200);
    run_phase(64'h0, 16'd4096, 300);

    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire
